FILE: hdl/gth_pkg.sv
package gth_pkg;

  localparam int unsigned EPOCH_DAY  = 1948439;
  localparam int unsigned CYCLE_DAYS = 10631;
  localparam int unsigned CYCLE_YEARS = 30;

  // bias so the day count entering the cycle divider is never negative
  localparam int unsigned CYCLE_BIAS = 23;
  localparam int unsigned YEAR_BIAS  = CYCLE_BIAS * CYCLE_YEARS;
  localparam int unsigned DAY_OFFSET = 1525 + EPOCH_DAY - 2 - CYCLE_BIAS * CYCLE_DAYS;

  // floor(y/100) as (y * CENT_MUL) >> CENT_SHIFT, exact for y below 43690
  localparam int unsigned CENT_MUL   = 5243;
  localparam int unsigned CENT_SHIFT = 19;

  // floor(x/CYCLE_DAYS) as (x * RECIP_MUL) >> RECIP_SHIFT, exact for x below 2^23
  localparam int unsigned RECIP_MUL   = 12928131;
  localparam int unsigned RECIP_SHIFT = 37;
  localparam int unsigned Q_W         = 10;

  localparam int unsigned DAY_W    = 24;

  localparam logic [31:0] LEAP_MASK = 32'h2525_24A4;

  typedef struct packed {
    logic load;
    logic calc1;
    logic calc2;
    logic div_mul;
    logic div_fix;
    logic year_step;
    logic month_step;
    logic emit;
  } gth_cmd_t;

  typedef struct packed {
    logic year_fit;
    logic month_fit;
    logic out_busy;
  } gth_status_t;

  function automatic logic pos_is_leap(input logic [4:0] pos);
    pos_is_leap = LEAP_MASK[pos];
  endfunction

  // floor(30.6001 * k)
  function automatic logic [8:0] month_days(input logic [4:0] k);
    logic [8:0] v;
    case (k)
      5'd1:    v = 9'd30;
      5'd2:    v = 9'd61;
      5'd3:    v = 9'd91;
      5'd4:    v = 9'd122;
      5'd5:    v = 9'd153;
      5'd6:    v = 9'd183;
      5'd7:    v = 9'd214;
      5'd8:    v = 9'd244;
      5'd9:    v = 9'd275;
      5'd10:   v = 9'd306;
      5'd11:   v = 9'd336;
      5'd12:   v = 9'd367;
      5'd13:   v = 9'd397;
      5'd14:   v = 9'd428;
      5'd15:   v = 9'd459;
      5'd16:   v = 9'd489;
      default: v = 9'd0;
    endcase
    month_days = v;
  endfunction

endpackage

FILE: hdl/gth_ctrl.sv
module gth_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  gth_pkg::gth_status_t status,
  output gth_pkg::gth_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC1,
    S_CALC2,
    S_DIV_MUL,
    S_DIV_FIX,
    S_YEAR,
    S_MONTH,
    S_DONE
  } state_t;

  state_t                     state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CALC1;
        end
      end
      S_CALC1: begin
        cmd.calc1 = 1'b1;
        state_nxt = S_CALC2;
      end
      S_CALC2: begin
        cmd.calc2   = 1'b1;
        state_nxt   = S_DIV_MUL;
      end
      S_DIV_MUL: begin
        cmd.div_mul = 1'b1;
        state_nxt   = S_DIV_FIX;
      end
      S_DIV_FIX: begin
        cmd.div_fix = 1'b1;
        state_nxt   = S_YEAR;
      end
      S_YEAR: begin
        if (status.year_fit) begin
          state_nxt = S_MONTH;
        end else begin
          cmd.year_step = 1'b1;
        end
      end
      S_MONTH: begin
        if (status.month_fit) begin
          state_nxt = S_DONE;
        end else begin
          cmd.month_step = 1'b1;
        end
      end
      S_DONE: begin
        // wait for the output register to be free
        if (!status.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
    end else begin
      state_r   <= state_nxt;
    end
  end

endmodule

FILE: hdl/gth_datapath.sv
module gth_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [23:0]          in_tdata,
  input  gth_pkg::gth_cmd_t    cmd,
  output gth_pkg::gth_status_t status,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata
);

  localparam int unsigned DW = gth_pkg::DAY_W;

  logic [13:0]              greg_year;
  logic [3:0]               greg_month;
  logic [4:0]               greg_day;

  logic signed [14:0]       y_adj_r;
  logic [4:0]               k_r;
  logic [4:0]               day_r;
  logic [24:0]              prod_r;
  logic [7:0]               cent_r;
  logic [DW-1:0]            rem_r;
  logic [46:0]              recip_r;
  logic [gth_pkg::Q_W-1:0]  q_r;
  logic [4:0]               pos_r;
  logic [3:0]               month_r;

  logic [13:0]              hijri_year_r;
  logic [3:0]               hijri_month_r;
  logic [4:0]               hijri_day_r;
  logic                     out_valid_r;

  logic [14:0]              yy;
  logic [13:0]              y_pos;
  logic [26:0]              cent_prod;
  logic [25:0]              day_sum;
  logic [8:0]               year_len;
  logic [4:0]               mon_len;
  logic [gth_pkg::Q_W-1:0]  quot;
  logic [DW-1:0]            cyc_sum;
  logic [15:0]              year_full;

  assign greg_year  = in_tdata[13:0];
  assign greg_month = in_tdata[17:14];
  assign greg_day   = in_tdata[22:18];

  always_comb begin
    yy        = 15'(y_adj_r + 15'sd4716);
    y_pos     = y_adj_r[14] ? 14'd0 : y_adj_r[13:0];
    cent_prod = 27'(y_pos) * 27'(gth_pkg::CENT_MUL);
    // julian day minus epoch, plus the cycle bias; positive for every input
    day_sum   = 26'(prod_r[24:2]) + 26'(gth_pkg::month_days(k_r)) + 26'(day_r)
              + 26'(cent_r[7:2]) - 26'(cent_r) - 26'(gth_pkg::DAY_OFFSET);
    year_len  = gth_pkg::pos_is_leap(pos_r) ? 9'd355 : 9'd354;
    if (month_r[0] || ((month_r == 4'd12) && gth_pkg::pos_is_leap(pos_r))) begin
      mon_len = 5'd30;
    end else begin
      mon_len = 5'd29;
    end
    quot       = recip_r[gth_pkg::RECIP_SHIFT +: gth_pkg::Q_W];
    cyc_sum    = DW'(quot) * DW'(gth_pkg::CYCLE_DAYS);
    year_full  = 16'({q_r, 5'b0}) - 16'({q_r, 1'b0}) + 16'(pos_r)
               - 16'(gth_pkg::YEAR_BIAS);
  end

  assign status.year_fit  = (rem_r < DW'(year_len));
  assign status.month_fit = (rem_r < DW'(mon_len));
  assign status.out_busy  = out_valid_r && !out_tready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      day_r <= greg_day;
      // january and february belong to the previous year
      if (greg_month <= 4'd2) begin
        y_adj_r <= $signed({1'b0, greg_year}) - 15'sd1;
        k_r     <= 5'(greg_month) + 5'd13;
      end else begin
        y_adj_r <= $signed({1'b0, greg_year});
        k_r     <= 5'(greg_month) + 5'd1;
      end
    end
    if (cmd.calc1) begin
      prod_r <= 25'(yy) * 25'd1461;
      cent_r <= cent_prod[gth_pkg::CENT_SHIFT +: 8];
    end
    if (cmd.calc2) begin
      rem_r     <= day_sum[DW-1:0];
      pos_r     <= 5'd1;
      month_r   <= 4'd1;
    end
    // day count stays below 2^23, so its low 23 bits carry it whole
    if (cmd.div_mul) begin
      recip_r <= 47'(rem_r[22:0]) * 47'(gth_pkg::RECIP_MUL);
    end
    if (cmd.div_fix) begin
      q_r   <= quot;
      rem_r <= rem_r - cyc_sum;
    end
    if (cmd.year_step) begin
      rem_r <= rem_r - DW'(year_len);
      pos_r <= pos_r + 5'd1;
    end
    if (cmd.month_step) begin
      rem_r   <= rem_r - DW'(mon_len);
      month_r <= month_r + 4'd1;
    end
    if (cmd.emit) begin
      hijri_year_r  <= year_full[13:0];
      hijri_month_r <= month_r;
      hijri_day_r   <= rem_r[4:0] + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, hijri_day_r, hijri_month_r, hijri_year_r};

  a_year_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.year_step |-> (pos_r < 5'd30))
    else $error("year walk ran past the end of the cycle");

  a_month_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.month_step |-> (month_r < 4'd12))
    else $error("month walk ran past the end of the year");

  a_cycle_rem: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.year_step |-> (rem_r < DW'(gth_pkg::CYCLE_DAYS)))
    else $error("cycle remainder out of range after division");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_tready))
    else $error("result written over a beat not yet taken");

endmodule

FILE: hdl/gregorian_to_hijri_date_unit.sv
// gregorian to tabular hijri date converter
//
// input channel (in_*): one beat carries a gregorian date, taken when
// in_tvalid and in_tready are both high. output channel (out_*): one beat
// carries the matching tabular hijri date for every input beat, in order.
// no configuration registers.
//
// per date: the setup multiplies, then the day sum; a split of the day
// count into 30-year cycles (a reciprocal multiply, then the remainder);
// then the year walk and the month walk, each a check step plus one step for
// every year or month passed over (0..29 and 0..11); then a step that loads
// the output register. in_tready returns high together with out_tvalid, so
// a new date is taken only after the last one has been loaded into the
// output register.
//
// reset (rst_n low, synchronous) returns the controller to idle and drops
// out_tvalid. while the receiver stalls, a finished result waits in the
// output register and the next date is still accepted and worked on; it
// holds in its last step until the output register is free.
module gregorian_to_hijri_date_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // greg_year[13:0], greg_month[17:14], greg_day[22:18], pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // hijri_year[13:0], hijri_month[17:14], hijri_day[22:18], pad
);

  gth_pkg::gth_cmd_t    cmd;
  gth_pkg::gth_status_t status;

  gth_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  gth_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
